/* hw/rtl/dbba_pkg.sv */
// ----------------------------------------------------------------------------
// dbba_pkg: shared types and constants of the block bitmap allocator
// Widths of the item fields, command and status codes, configuration
// register indexes, and the controller state type.
// ----------------------------------------------------------------------------
package dbba_pkg;

    // Defaults of the top level parameters
    localparam int NUM_BLOCKS_DEF      = 8192;
    localparam int MAX_FILE_BLOCKS_DEF = 64;

    // Field widths
    localparam int BLK_W     = 13;
    localparam int SIZE_W    = 32;
    localparam int BSIZE_W   = 17;
    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;

    // Wide block index (covers the largest disk and reserved_blocks + 1)
    localparam int IDX_W = 17;

    // Map row geometry: one RAM word holds the used bits of 32 blocks
    localparam int ROW_BITS = 32;
    localparam int ROW_LG   = 5;

    // Block count width: holds MAX_FILE_BLOCKS + 2
    localparam int CNT_W = 7;

    // Register reset values
    localparam logic [BLK_W-1:0]   RESERVED_RST = 13'd2;
    localparam logic [BSIZE_W-1:0] BSIZE_RST    = 17'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_TOO_LARGE = 2'd2,
        STAT_EMPTY     = 2'd3
    } stat_t;

    typedef struct packed {
        logic [BLK_W-1:0]   reserved;
        logic [BSIZE_W-1:0] block_size;
    } cfg_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] total;
    } sizer_res_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_COUNT,
        S_ALLOC_RD,
        S_ALLOC_LOAD,
        S_ALLOC_PICK,
        S_REPORT,
        S_FREE_RD,
        S_FREE_WR
    } eng_state_t;

endpackage

/* hw/rtl/dbba_ram.sv */
// ----------------------------------------------------------------------------
// dbba_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dbba_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data between reads
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/dbba_sizer.sv */
// ----------------------------------------------------------------------------
// dbba_sizer: block count of a file
// Counts data blocks as ceil(size / block_size) by repeated subtraction,
// one block a cycle, and stops early once the count passes the file limit.
// Adds the index block when more than one data block is needed.
// ----------------------------------------------------------------------------
module dbba_sizer #(
    parameter int MAX_FILE_BLOCKS = dbba_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [dbba_pkg::SIZE_W-1:0]  size,
    input  logic [dbba_pkg::BSIZE_W-1:0] bsize,
    output dbba_pkg::sizer_res_t         res
);

    import dbba_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FILE_BLOCKS);

    logic              active_reg, active_next;
    logic              done_reg, done_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SIZE_W-1:0] bsize_ext;
    logic              fin;

    assign bsize_ext = SIZE_W'(bsize);
    assign cnt_inc   = cnt_reg + CNT_W'(1);
    // Last partial block reached, or already past the limit
    assign fin       = (rem_reg <= bsize_ext) || (cnt_inc > MAX_CNT);

    // Subtract one block per cycle
    always_comb
    begin
        active_next = active_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        if (start)
        begin
            active_next = 1'b1;
            rem_next    = size;
            cnt_next    = '0;
        end
        else if (active_reg)
        begin
            cnt_next = cnt_inc;
            rem_next = rem_reg - bsize_ext;
            if (fin)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
                total_next  = (cnt_inc > CNT_W'(1)) ? cnt_inc + CNT_W'(1) : cnt_inc;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
    end

    assign res.done  = done_reg;
    assign res.total = total_reg;

endmodule

/* hw/rtl/dbba_engine.sv */
// ----------------------------------------------------------------------------
// dbba_engine: free map controller
// Holds the used map in a RAM of 32-bit rows. Sweeps the map clear, counts
// free blocks over the search range, claims blocks first-fit and frees them
// by read-modify-write of one row at a time, and drives the result register.
// ----------------------------------------------------------------------------
module dbba_engine #(
    parameter int NUM_BLOCKS      = dbba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_FILE_BLOCKS = dbba_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dbba_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dbba_pkg::CMD_W-1:0]   cmd,
    input  logic [dbba_pkg::SIZE_W-1:0]  file_size,
    input  logic [dbba_pkg::BLK_W-1:0]   block_number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dbba_pkg::BLK_W-1:0]   block_number_out,
    output logic                         index_block,
    output logic [dbba_pkg::STAT_W-1:0]  status,
    output logic                         last
);

    import dbba_pkg::*;

    localparam int ROWS  = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
    localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_W = $clog2(ROWS + 1);
    localparam int TAIL  = NUM_BLOCKS % ROW_BITS;

    localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [ROW_BITS-1:0] LAST_MASK = (TAIL == 0) ? {ROW_BITS{1'b1}}
                                              : ({ROW_BITS{1'b1}} >> (ROW_BITS - TAIL));
    localparam logic [IDX_W-1:0]    NB        = IDX_W'(NUM_BLOCKS);
    localparam logic [CNT_W-1:0]    MAX_CNT   = CNT_W'(MAX_FILE_BLOCKS);

    // Bits of a row that lie inside the search range
    function automatic logic [ROW_BITS-1:0] row_mask(input logic [ROW_W-1:0]  row,
                                                      input logic [ROW_W-1:0]  srow,
                                                      input logic [ROW_LG-1:0] slo);
        logic [ROW_BITS-1:0] m;
        m = {ROW_BITS{1'b1}};
        if (row == srow)
        begin
            m = m << slo;
        end
        if (row == LAST_ROW)
        begin
            m = m & LAST_MASK;
        end
        return m;
    endfunction

    function automatic logic [ROW_LG:0] pop_count(input logic [ROW_BITS-1:0] v);
        logic [ROW_LG:0] c;
        c = '0;
        for (int i = 0; i < ROW_BITS; i++)
        begin
            c = c + (ROW_LG + 1)'(v[i]);
        end
        return c;
    endfunction

    function automatic logic [ROW_LG-1:0] lowest_set(input logic [ROW_BITS-1:0] v);
        logic [ROW_LG-1:0] p;
        p = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                p = ROW_LG'(i);
            end
        end
        return p;
    endfunction

    eng_state_t          state_reg, state_next;
    logic [ROW_W-1:0]    rd_row_reg, rd_row_next;
    logic [ROW_W-1:0]    pend_row_reg, pend_row_next;
    logic                pend_reg, pend_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ROW_BITS-1:0] map_reg, map_next;
    logic [ROW_LG-1:0]   bit_reg, bit_next;
    logic [CNT_W-1:0]    avail_reg, avail_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    stat_t               rep_stat_reg, rep_stat_next;

    logic                out_valid_reg, out_valid_next;
    logic [BLK_W-1:0]    out_blk_reg, out_blk_next;
    logic                out_idx_reg, out_idx_next;
    stat_t               out_stat_reg, out_stat_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we, ram_re;
    logic [RAW-1:0]      ram_waddr, ram_raddr;
    logic [ROW_BITS-1:0] ram_wdata, ram_rdata;

    logic                emit, emit_idx, emit_last;
    logic [BLK_W-1:0]    emit_blk;
    stat_t               emit_stat;
    logic                slot_free;

    logic [IDX_W-1:0]        start_blk;
    logic [IDX_W-ROW_LG-1:0] start_hi;
    logic [ROW_W-1:0]        start_row;
    logic [ROW_LG-1:0]       start_lo;
    logic                    range_empty;
    logic [BSIZE_W-1:0]      bsize_eff;
    logic                    blk_in_range;

    logic [ROW_BITS-1:0] free_bits, cnt_bits, map_set;
    logic                any_free, issue;
    logic [ROW_LG-1:0]   pick;
    logic [IDX_W-1:0]    blk_full;
    logic [CNT_W-1:0]    avail_sum, k_inc;

    logic                sz_start;
    sizer_res_t          sz;

    // Map storage
    dbba_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // File size to block count
    dbba_sizer #(
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_sizer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sz_start),
        .size  (file_size),
        .bsize (bsize_eff),
        .res   (sz)
    );

    // Search range and configuration decode
    assign start_blk    = IDX_W'(cfg.reserved) + IDX_W'(1);
    assign start_hi     = start_blk[IDX_W-1:ROW_LG];
    assign start_row    = ROW_W'(start_hi);
    assign start_lo     = start_blk[ROW_LG-1:0];
    assign range_empty  = (start_blk >= NB);
    assign bsize_eff    = (cfg.block_size == '0) ? BSIZE_W'(1) : cfg.block_size;
    assign blk_in_range = (IDX_W'(block_number) < NB);

    // Row scan helpers
    assign free_bits = ~map_reg & row_mask(cur_row_reg, start_row, start_lo);
    assign any_free  = |free_bits;
    assign pick      = lowest_set(free_bits);
    assign map_set   = map_reg | (ROW_BITS'(1) << pick);
    assign blk_full  = IDX_W'({cur_row_reg, pick});
    assign cnt_bits  = ~ram_rdata & row_mask(pend_row_reg, start_row, start_lo);
    assign avail_sum = avail_reg + CNT_W'(pop_count(cnt_bits));
    assign k_inc     = k_reg + CNT_W'(1);
    assign issue     = (rd_row_reg <= LAST_ROW);

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        rd_row_next   = rd_row_reg;
        pend_row_next = pend_row_reg;
        pend_next     = pend_reg;
        cur_row_next  = cur_row_reg;
        map_next      = map_reg;
        bit_next      = bit_reg;
        avail_next    = avail_reg;
        total_next    = total_reg;
        k_next        = k_reg;
        rep_stat_next = rep_stat_reg;

        ram_we    = 1'b0;
        ram_waddr = RAW'(cur_row_reg);
        ram_wdata = map_reg;
        ram_re    = 1'b0;
        ram_raddr = RAW'(cur_row_reg);

        emit      = 1'b0;
        emit_blk  = '0;
        emit_idx  = 1'b0;
        emit_stat = STAT_OK;
        emit_last = 1'b1;
        sz_start  = 1'b0;

        case (state_reg)
            // Sweep zeros through every row
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = RAW'(rd_row_reg);
                ram_wdata = '0;
                if (rd_row_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_row_next = rd_row_reg + ROW_W'(1);
                end
            end

            // Take a command
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(cmd))
                        CMD_ALLOC:
                        begin
                            if (file_size == '0)
                            begin
                                rep_stat_next = STAT_EMPTY;
                                state_next    = S_REPORT;
                            end
                            else
                            begin
                                sz_start   = 1'b1;
                                state_next = S_SIZE;
                            end
                        end
                        CMD_FREE:
                        begin
                            if (blk_in_range)
                            begin
                                cur_row_next = ROW_W'(block_number[BLK_W-1:ROW_LG]);
                                bit_next     = block_number[ROW_LG-1:0];
                                state_next   = S_FREE_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            rd_row_next = '0;
                            state_next  = S_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Wait for the block count, then check the limits
            S_SIZE:
            begin
                if (sz.done)
                begin
                    total_next = sz.total;
                    if (sz.total > MAX_CNT)
                    begin
                        rep_stat_next = STAT_TOO_LARGE;
                        state_next    = S_REPORT;
                    end
                    else if (range_empty)
                    begin
                        rep_stat_next = STAT_NO_SPACE;
                        state_next    = S_REPORT;
                    end
                    else
                    begin
                        rd_row_next = start_row;
                        pend_next   = 1'b0;
                        avail_next  = '0;
                        state_next  = S_COUNT;
                    end
                end
            end

            // Stream rows and count free blocks until enough are found
            S_COUNT:
            begin
                ram_re        = issue;
                ram_raddr     = RAW'(rd_row_reg);
                pend_next     = issue;
                pend_row_next = rd_row_reg;
                if (issue)
                begin
                    rd_row_next = rd_row_reg + ROW_W'(1);
                end
                if (pend_reg)
                begin
                    avail_next = avail_sum;
                end
                if (pend_reg && (avail_sum >= total_reg))
                begin
                    cur_row_next = start_row;
                    k_next       = '0;
                    state_next   = S_ALLOC_RD;
                end
                else if (!issue && !pend_reg)
                begin
                    rep_stat_next = STAT_NO_SPACE;
                    state_next    = S_REPORT;
                end
            end

            S_ALLOC_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_ALLOC_LOAD;
            end

            S_ALLOC_LOAD:
            begin
                map_next   = ram_rdata;
                state_next = S_ALLOC_PICK;
            end

            // Claim the lowest free block of the row, one per cycle while the output slot is free
            S_ALLOC_PICK:
            begin
                if (any_free)
                begin
                    if (slot_free)
                    begin
                        emit      = 1'b1;
                        emit_blk  = blk_full[BLK_W-1:0];
                        emit_idx  = (k_reg == '0) && (total_reg > CNT_W'(1));
                        emit_last = (k_inc == total_reg);
                        map_next  = map_set;
                        k_next    = k_inc;
                        if (k_inc == total_reg)
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = map_set;
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    ram_we       = 1'b1;
                    cur_row_next = cur_row_reg + ROW_W'(1);
                    state_next   = S_ALLOC_RD;
                end
            end

            // Single status result
            S_REPORT:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_stat  = rep_stat_reg;
                    state_next = S_IDLE;
                end
            end

            S_FREE_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_FREE_WR;
            end

            S_FREE_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(ROW_BITS'(1) << bit_reg);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result register: load on emit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_blk_next   = out_blk_reg;
        out_idx_next   = out_idx_reg;
        out_stat_next  = out_stat_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_blk_next   = emit_blk;
            out_idx_next   = emit_idx;
            out_stat_next  = emit_stat;
            out_last_next  = emit_last;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rd_row_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_row_reg    <= rd_row_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        pend_row_reg <= pend_row_next;
        cur_row_reg  <= cur_row_next;
        map_reg      <= map_next;
        bit_reg      <= bit_next;
        avail_reg    <= avail_next;
        total_reg    <= total_next;
        k_reg        <= k_next;
        rep_stat_reg <= rep_stat_next;
        out_blk_reg  <= out_blk_next;
        out_idx_reg  <= out_idx_next;
        out_stat_reg <= out_stat_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid        = out_valid_reg;
    assign block_number_out = out_blk_reg;
    assign index_block      = out_idx_reg;
    assign status           = out_stat_reg;
    assign last             = out_last_reg;

    // Claimed blocks stay inside the search range
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (state_reg == S_ALLOC_PICK)) |-> ((blk_full >= start_blk) && (blk_full < NB)))
        else $error("allocated block outside search range");

    // Never pick more blocks than the file needs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC_PICK) |-> (k_reg < total_reg))
        else $error("allocation count overran total");

    // Map accesses never overlap: read and write-back are serialized
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !ram_re)
        else $error("map read and write in the same cycle");

    // Sizer answers only while waiting for it, and never with zero blocks
    assert property (@(posedge clk) disable iff (!rst_n)
        sz.done |-> ((state_reg == S_SIZE) && (sz.total != '0)))
        else $error("unexpected block count");

    // An index block result is an ok result and never the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_idx_reg) |-> ((out_stat_reg == STAT_OK) && !out_last_reg))
        else $error("index block flag on a wrong result");

endmodule

/* hw/rtl/disk_block_bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// disk_block_bitmap_allocator: first-fit free block allocator of a disk
// Keeps one used bit per disk block and serves allocate, free-one-block and
// clear-map commands. Allocation results come out one block per item.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_stall    | cmd, file_size, block_number
//   out     | out       | out_valid/out_stall  | block_number_out,
//           |           |                      | index_block, status, last
//
// Allocate: sizes the file by one subtract per data block, counts free
//   blocks one map row per cycle, then reads, loads and scans each map row
//   visited and gives its free blocks lowest first.
// Free is a read-modify-write of one map row; clear rewrites every map row.
// After reset every map row is swept clear; in_stall stays high meanwhile,
//   cfg writes are taken.
// A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module disk_block_bitmap_allocator #(
    parameter int NUM_BLOCKS      = dbba_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_FILE_BLOCKS = dbba_pkg::MAX_FILE_BLOCKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dbba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dbba_pkg::BSIZE_W-1:0]   cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [dbba_pkg::CMD_W-1:0]     cmd,
    input  logic [dbba_pkg::SIZE_W-1:0]    file_size,
    input  logic [dbba_pkg::BLK_W-1:0]     block_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [dbba_pkg::BLK_W-1:0]     block_number_out,
    output logic                           index_block,
    output logic [dbba_pkg::STAT_W-1:0]    status,
    output logic                           last
);

    import dbba_pkg::*;

    logic [BLK_W-1:0]   reserved_reg, reserved_next;
    logic [BSIZE_W-1:0] bsize_reg, bsize_next;
    cfg_t               cfg;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb
    begin
        reserved_next = reserved_reg;
        bsize_next    = bsize_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_RESERVED:
                begin
                    reserved_next = cfg_data[BLK_W-1:0];
                end
                CFG_BLOCK_SIZE:
                begin
                    bsize_next = cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= RESERVED_RST;
            bsize_reg    <= BSIZE_RST;
        end
        else
        begin
            reserved_reg <= reserved_next;
            bsize_reg    <= bsize_next;
        end
    end

    assign cfg.reserved   = reserved_reg;
    assign cfg.block_size = bsize_reg;

    dbba_engine #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
    ) u_engine (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .file_size        (file_size),
        .block_number     (block_number),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .block_number_out (block_number_out),
        .index_block      (index_block),
        .status           (status),
        .last             (last)
    );

endmodule
